// ===== src/pfr_pkg.sv =====
// Shared types and constants for the pixel format repacker.
package pfr_pkg;

  // Source pixel formats as held in the format register. Codes above the last
  // member decode as RGBA8888.
  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGBX8888 = 3'd1,
    FMT_BGRA8888 = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_RGB565   = 3'd4
  } pfr_format_e;

  // Register indexes; register i lies at byte address 4*i.
  typedef enum logic [2:0] {
    REG_SOURCE_FORMAT  = 3'd0,
    REG_SWAP_RED_BLUE  = 3'd1,
    REG_DEST_BPP       = 3'd2,
    REG_RED_LAYOUT     = 3'd3,
    REG_GREEN_LAYOUT   = 3'd4,
    REG_BLUE_LAYOUT    = 3'd5,
    REG_ALPHA_LAYOUT   = 3'd6
  } pfr_reg_e;

  localparam int unsigned PixelBits    = 32;
  localparam int unsigned ColumnBits   = 12;
  localparam int unsigned FirstBitBits = 17;
  localparam int unsigned LayoutBits   = 12;
  localparam int unsigned AddrBits     = 5;

  localparam logic [5:0]  MaxFieldLen  = 6'd32;
  localparam logic [15:0] QuantBias    = 16'd127;
  localparam logic [7:0]  OpaqueAlpha  = 8'hff;

  // Reset values of the configuration registers.
  localparam logic [2:0]  RstFormat    = 3'd0;
  localparam logic        RstSwap      = 1'b0;
  localparam logic [5:0]  RstBpp       = 6'd32;
  localparam logic [11:0] RstRedLayout   = 12'd272;
  localparam logic [11:0] RstGreenLayout = 12'd264;
  localparam logic [11:0] RstBlueLayout  = 12'd256;
  localparam logic [11:0] RstAlphaLayout = 12'd0;

  // Decoded placement of one destination field. The length is clamped to 32
  // and split into whole bytes and a remainder, which the quantiser uses.
  typedef struct packed {
    logic [4:0] offset;
    logic [5:0] length;
    logic [2:0] frac;
    logic [2:0] bytes;
    logic [4:0] rshift;
    logic       rev;
  } pfr_layout_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [2:0]  format;
    logic        swap;
    logic [5:0]  bpp;
    pfr_layout_t red;
    pfr_layout_t green;
    pfr_layout_t blue;
    pfr_layout_t alpha;
  } pfr_cfg_t;

  // Unpacked 8-bit channels.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pfr_rgba_t;

endpackage

// ===== src/pixel_format_repacker_core.sv =====
// Top level of the pixel format repacker: stream pipeline and register port.
// The accepted input beat passes through the input register, then the result
// register, before the result beat appears on the master side.
// Throughput: one beat per cycle, set by the single-pass datapath between the
// two registers; while a result waits the input side takes one more beat, then stalls.
// Reset (rst_ni low, asynchronous) empties both pipeline stages and returns
// every configuration register to its documented reset value.
module pixel_format_repacker_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side. tdata: source_pixel [31:0], pixel_column [43:32], zero fill.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,
  // Master side. tdata: packed_pixel [31:0], row bit position [48:32], zero fill.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [55:0]                        m_axis_tdata,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfr_pkg::AddrBits-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // Saturation bound for the column. The width range tops out at 65536,
  // which still fits in the width of the row bit position.
  localparam logic [16:0] MaxWidthW = 17'(MAX_WIDTH);
  localparam logic [16:0] LastColW  = 17'(MAX_WIDTH - 1);

  pfr_pkg::pfr_cfg_t  cfg;
  pfr_pkg::pfr_rgba_t rgba;

  // Input register stage.
  logic                               in_valid_q;
  logic [31:0]                        pixel_q;
  logic [pfr_pkg::ColumnBits-1:0]     column_q;
  logic                               in_advance;

  // Result register stage.
  logic                               out_valid_q;
  logic [31:0]                        packed_q;
  logic [pfr_pkg::FirstBitBits-1:0]   row_bit_q;

  logic [31:0]                        red_field;
  logic [31:0]                        green_field;
  logic [31:0]                        blue_field;
  logic [31:0]                        alpha_field;
  logic [31:0]                        packed_d;
  logic [16:0]                        column_ext;
  logic [11:0]                        column_sat;
  logic [17:0]                        bit_product;
  logic [pfr_pkg::FirstBitBits-1:0]   row_bit_d;

  pfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The input stage moves on whenever the result register is empty or its
  // beat is being taken this cycle, so a stalled output holds both stages
  // only once both are full.
  assign in_advance    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || in_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pixel_q  <= s_axis_tdata[31:0];
      column_q <= s_axis_tdata[43:32];
    end
  end

  // Datapath: unpack, then quantise and place the four fields in parallel.
  pfr_unpack u_unpack (
    .pixel_i  (pixel_q),
    .format_i (cfg.format),
    .swap_i   (cfg.swap),
    .rgba_o   (rgba)
  );

  pfr_chan_place u_place_red (
    .value_i  (rgba.r),
    .layout_i (cfg.red),
    .field_o  (red_field)
  );

  pfr_chan_place u_place_green (
    .value_i  (rgba.g),
    .layout_i (cfg.green),
    .field_o  (green_field)
  );

  pfr_chan_place u_place_blue (
    .value_i  (rgba.b),
    .layout_i (cfg.blue),
    .field_o  (blue_field)
  );

  pfr_chan_place u_place_alpha (
    .value_i  (rgba.a),
    .layout_i (cfg.alpha),
    .field_o  (alpha_field)
  );

  assign packed_d = red_field | green_field | blue_field | alpha_field;

  // Row bit position. A column at or beyond the configured width is held at
  // the last column; the saturated value always fits in the column width.
  always_comb begin
    column_ext  = {5'd0, column_q};
    column_sat  = (column_ext >= MaxWidthW) ? LastColW[11:0] : column_q;
    bit_product = {6'd0, column_sat} * {12'd0, cfg.bpp};
    row_bit_d   = bit_product[pfr_pkg::FirstBitBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && in_advance) begin
      packed_q  <= packed_d;
      row_bit_q <= row_bit_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, row_bit_q, packed_q};

endmodule

// ===== src/pfr_regs.sv =====
// Configuration register file with APB-style access and layout decoding.
module pfr_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfr_pkg::AddrBits-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output pfr_pkg::pfr_cfg_t                 cfg_o
);

  logic [2:0]  format_q;
  logic        swap_q;
  logic [5:0]  bpp_q;
  logic [11:0] red_layout_q;
  logic [11:0] green_layout_q;
  logic [11:0] blue_layout_q;
  logic [11:0] alpha_layout_q;
  logic        wr_en;
  pfr_pkg::pfr_reg_e reg_idx;

  function automatic pfr_pkg::pfr_layout_t decode_layout(input logic [11:0] raw);
    logic [5:0]           len;
    pfr_pkg::pfr_layout_t lay;
    len        = (raw[10:5] > pfr_pkg::MaxFieldLen) ? pfr_pkg::MaxFieldLen : raw[10:5];
    lay.offset = raw[4:0];
    lay.length = len;
    lay.frac   = len[2:0];
    lay.bytes  = len[5:3];
    lay.rshift = 5'(pfr_pkg::MaxFieldLen - len);
    lay.rev    = raw[11];
    return lay;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = pfr_pkg::pfr_reg_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q       <= pfr_pkg::RstFormat;
      swap_q         <= pfr_pkg::RstSwap;
      bpp_q          <= pfr_pkg::RstBpp;
      red_layout_q   <= pfr_pkg::RstRedLayout;
      green_layout_q <= pfr_pkg::RstGreenLayout;
      blue_layout_q  <= pfr_pkg::RstBlueLayout;
      alpha_layout_q <= pfr_pkg::RstAlphaLayout;
    end else if (wr_en) begin
      case (reg_idx)
        pfr_pkg::REG_SOURCE_FORMAT: format_q       <= pwdata[2:0];
        pfr_pkg::REG_SWAP_RED_BLUE: swap_q         <= pwdata[0];
        pfr_pkg::REG_DEST_BPP:      bpp_q          <= pwdata[5:0];
        pfr_pkg::REG_RED_LAYOUT:    red_layout_q   <= pwdata[11:0];
        pfr_pkg::REG_GREEN_LAYOUT:  green_layout_q <= pwdata[11:0];
        pfr_pkg::REG_BLUE_LAYOUT:   blue_layout_q  <= pwdata[11:0];
        pfr_pkg::REG_ALPHA_LAYOUT:  alpha_layout_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfr_pkg::REG_SOURCE_FORMAT: prdata = {29'd0, format_q};
      pfr_pkg::REG_SWAP_RED_BLUE: prdata = {31'd0, swap_q};
      pfr_pkg::REG_DEST_BPP:      prdata = {26'd0, bpp_q};
      pfr_pkg::REG_RED_LAYOUT:    prdata = {20'd0, red_layout_q};
      pfr_pkg::REG_GREEN_LAYOUT:  prdata = {20'd0, green_layout_q};
      pfr_pkg::REG_BLUE_LAYOUT:   prdata = {20'd0, blue_layout_q};
      pfr_pkg::REG_ALPHA_LAYOUT:  prdata = {20'd0, alpha_layout_q};
      default:                    prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg_o.format = format_q;
    cfg_o.swap   = swap_q;
    cfg_o.bpp    = (bpp_q > pfr_pkg::MaxFieldLen) ? pfr_pkg::MaxFieldLen : bpp_q;
    cfg_o.red    = decode_layout(red_layout_q);
    cfg_o.green  = decode_layout(green_layout_q);
    cfg_o.blue   = decode_layout(blue_layout_q);
    cfg_o.alpha  = decode_layout(alpha_layout_q);
  end

endmodule

// ===== src/pfr_unpack.sv =====
// Source pixel unpacking to 8-bit channels, with optional red/blue exchange.
module pfr_unpack (
  input  logic [31:0]         pixel_i,
  input  logic [2:0]          format_i,
  input  logic                swap_i,
  output pfr_pkg::pfr_rgba_t  rgba_o
);

  pfr_pkg::pfr_rgba_t ch;

  always_comb begin
    case (pfr_pkg::pfr_format_e'(format_i))
      pfr_pkg::FMT_RGBX8888: begin
        ch = '{r: pixel_i[7:0], g: pixel_i[15:8], b: pixel_i[23:16],
               a: pfr_pkg::OpaqueAlpha};
      end
      pfr_pkg::FMT_BGRA8888: begin
        ch = '{r: pixel_i[23:16], g: pixel_i[15:8], b: pixel_i[7:0], a: pixel_i[31:24]};
      end
      pfr_pkg::FMT_RGB888: begin
        ch = '{r: pixel_i[7:0], g: pixel_i[15:8], b: pixel_i[23:16],
               a: pfr_pkg::OpaqueAlpha};
      end
      pfr_pkg::FMT_RGB565: begin
        // Widen by repeating the top bits of each channel below it.
        ch = '{r: {pixel_i[15:11], pixel_i[15:13]},
               g: {pixel_i[10:5], pixel_i[10:9]},
               b: {pixel_i[4:0], pixel_i[4:2]},
               a: pfr_pkg::OpaqueAlpha};
      end
      default: begin
        ch = '{r: pixel_i[7:0], g: pixel_i[15:8], b: pixel_i[23:16], a: pixel_i[31:24]};
      end
    endcase

    rgba_o = ch;
    if (swap_i) begin
      rgba_o.r = ch.b;
      rgba_o.b = ch.r;
    end
  end

endmodule

// ===== src/pfr_chan_place.sv =====
// Quantisation, optional bit reversal and placement of one destination field.
module pfr_chan_place (
  input  logic [7:0]            value_i,
  input  pfr_pkg::pfr_layout_t  layout_i,
  output logic [31:0]           field_o
);

  // With length L = 8m + s, v*(2^L-1)/255 splits exactly into
  // (v << s) * 0x0101..01 (m bytes) plus the s-bit quantisation of v, since
  // 256^m leaves remainder one modulo 255. The two parts never overlap.
  logic [14:0] shifted;
  logic [31:0] whole;
  logic [15:0] rem_num;
  logic [15:0] rem_sum;
  logic [31:0] quant;
  logic [31:0] mirrored;
  logic [31:0] chosen;

  always_comb begin
    shifted = {7'd0, value_i} << layout_i.frac;
    whole   = '0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < layout_i.bytes) begin
        whole = whole + (32'(shifted) << (8 * j));
      end
    end

    // Rounded small part; the numerator stays below 2^15, where
    // (x + (x >> 8) + 1) >> 8 equals x / 255.
    rem_num = 16'(shifted) - 16'(value_i) + pfr_pkg::QuantBias;
    rem_sum = rem_num + (rem_num >> 8) + 16'd1;
    quant   = whole | {24'd0, rem_sum[15:8]};

    for (int k = 0; k < 32; k++) begin
      mirrored[k] = quant[31 - k];
    end

    chosen  = layout_i.rev ? (mirrored >> layout_i.rshift) : quant;
    field_o = (layout_i.length == 6'd0) ? 32'd0 : (chosen << layout_i.offset);
  end

endmodule
